// ===== src/wcsp_pkg.sv =====
// ----------------------------------------------------------------------------
// wcsp_pkg
// Shared widths, register indexes and beat types for the column span plotter.
// ----------------------------------------------------------------------------
package wcsp_pkg;

  localparam int SAMPLE_W    = 16;
  localparam int RECT_X_W    = 9;
  localparam int RECT_Y_W    = 8;
  localparam int HEIGHT_W    = 8;
  localparam int DEC_W       = 16;
  localparam int SHIFT_W     = 4;
  localparam int COL_X_W     = 10;
  localparam int ROW_W       = 8;
  localparam int COUNT_W     = 17;
  localparam int INDEX_W     = 17;
  localparam int MAX_COL_W   = 9;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;

  localparam int DEF_FRAME_WIDTH   = 320;
  localparam int DEF_FRAME_HEIGHT  = 240;
  localparam int DEF_GRAPH_COLUMNS = 256;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_RECT_X      = 3'd0,
    REG_RECT_Y      = 3'd1,
    REG_RECT_HEIGHT = 3'd2,
    REG_DECIMATION  = 3'd3,
    REG_AMP_SHIFT   = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic [RECT_X_W-1:0] rect_x;
    logic [RECT_Y_W-1:0] rect_y;
    logic [HEIGHT_W-1:0] rect_height;
    logic [DEC_W-1:0]    decimation;
    logic [SHIFT_W-1:0]  amp_shift;
  } cfg_t;

  // one span to compute: the two kept samples and where it lands
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic signed [SAMPLE_W-1:0] prev;
    logic [MAX_COL_W-1:0]       col;
    logic                       last;
  } span_req_t;

  typedef struct packed {
    logic [COL_X_W-1:0] column_x;
    logic [ROW_W-1:0]   top_row;
    logic [COUNT_W-1:0] pixel_count;
    logic [INDEX_W-1:0] start_index;
    logic               last_column;
  } span_t;

endpackage

// ===== src/waveform_column_span_plotter_core.sv =====
// ----------------------------------------------------------------------------
// waveform_column_span_plotter_core
// Decimates a sample stream and emits one vertical span beat per pair of
// neighbouring kept samples.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake         | payload
//  ---------+-----------+-------------------+-----------------------------------
//  in       | in        | in_valid/in_stall | sample, first_of_block
//  out      | out       | out_valid/out_stall | column_x, top_row, pixel_count,
//           |           |                   | start_index, last_column
//  config   | in        | wr_en             | wr_index, wr_data
//
//  One input beat per cycle while in_stall is low; results are registered
//  in the span register, whose feed into the output register sets throughput.
//  Synchronous reset clears counters, previous sample and both valids.
//  out_stall holds the output register and, once the span register is
//  also full, raises in_stall.
// ----------------------------------------------------------------------------
module waveform_column_span_plotter_core
  import wcsp_pkg::*;
#(
  parameter int FRAME_WIDTH   = DEF_FRAME_WIDTH,
  parameter int FRAME_HEIGHT  = DEF_FRAME_HEIGHT,
  parameter int GRAPH_COLUMNS = DEF_GRAPH_COLUMNS
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       wr_en,
  input  logic [CFG_INDEX_W-1:0]     wr_index,
  input  logic [CFG_DATA_W-1:0]      wr_data,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic signed [SAMPLE_W-1:0] sample,
  input  logic                       first_of_block,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [COL_X_W-1:0]         column_x,
  output logic [ROW_W-1:0]           top_row,
  output logic [COUNT_W-1:0]         pixel_count,
  output logic [INDEX_W-1:0]         start_index,
  output logic                       last_column
);

  localparam int CIW = $clog2(GRAPH_COLUMNS + 1);

  cfg_t                       cfg;
  logic [DEC_W-1:0]           phase_count;
  logic [CIW-1:0]             column_index;
  logic signed [SAMPLE_W-1:0] previous_kept;

  logic [DEC_W-1:0]   phase_eff;
  logic [CIW-1:0]     col_eff;
  logic [DEC_W-1:0]   dec_eff;
  logic [DEC_W:0]     phase_inc;
  logic [DEC_W-1:0]   phase_count_next;
  logic [CIW-1:0]     col_m1;
  logic               kept;
  logic               take;
  logic               produce;
  logic               in_accept;
  logic               o_load;

  span_req_t req_next;
  span_req_t req;
  logic      req_valid;
  span_t     span_next;
  span_t     span;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.rect_x      <= '0;
      cfg.rect_y      <= '0;
      cfg.rect_height <= '0;
      cfg.decimation  <= DEC_W'(1);
      cfg.amp_shift   <= '0;
    end else if (wr_en) begin
      unique case (cfg_reg_t'(wr_index))
        REG_RECT_X:      cfg.rect_x      <= wr_data[RECT_X_W-1:0];
        REG_RECT_Y:      cfg.rect_y      <= wr_data[RECT_Y_W-1:0];
        REG_RECT_HEIGHT: cfg.rect_height <= wr_data[HEIGHT_W-1:0];
        REG_DECIMATION:  cfg.decimation  <= wr_data[DEC_W-1:0];
        REG_AMP_SHIFT:   cfg.amp_shift   <= wr_data[SHIFT_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_accept = in_valid && !in_stall;
  assign o_load    = req_valid && (!out_valid || !out_stall);
  assign in_stall  = req_valid && !o_load;

  always_comb begin
    phase_eff        = first_of_block ? '0 : phase_count;
    col_eff          = first_of_block ? '0 : column_index;
    dec_eff          = (cfg.decimation == '0) ? DEC_W'(1) : cfg.decimation;
    kept             = (phase_eff == '0);
    phase_inc        = {1'b0, phase_eff} + (DEC_W + 1)'(1);
    phase_count_next = (phase_inc >= {1'b0, dec_eff}) ? '0 : phase_inc[DEC_W-1:0];
    take             = kept && (col_eff < CIW'(GRAPH_COLUMNS));
    produce          = take && (col_eff != '0);
    col_m1           = col_eff - CIW'(1);
    req_next.sample  = sample;
    req_next.prev    = previous_kept;
    req_next.col     = MAX_COL_W'(col_m1);
    req_next.last    = (col_m1 == CIW'(GRAPH_COLUMNS - 2));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_count   <= '0;
      column_index  <= '0;
      previous_kept <= '0;
    end else if (in_accept) begin
      phase_count <= phase_count_next;
      if (take) begin
        previous_kept <= sample;
        column_index  <= col_eff + CIW'(1);
      end else begin
        column_index <= col_eff;
      end
    end
  end

  // span register
  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (in_accept) begin
      req_valid <= produce;
    end else if (o_load) begin
      req_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept && produce) begin
      req <= req_next;
    end
  end

  wcsp_span_calc #(
    .FRAME_WIDTH (FRAME_WIDTH),
    .FRAME_HEIGHT(FRAME_HEIGHT)
  ) u_span_calc (
    .cfg (cfg),
    .req (req),
    .span(span_next)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (o_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (o_load) begin
      span <= span_next;
    end
  end

  assign column_x    = span.column_x;
  assign top_row     = span.top_row;
  assign pixel_count = span.pixel_count;
  assign start_index = span.start_index;
  assign last_column = span.last_column;

`ifndef SYNTH
  a_stall_needs_pending: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> req_valid)
    else $error("input stalled with empty span register");

  a_span_captured: assert property (@(posedge clk) disable iff (rst)
    (in_accept && produce) |=> req_valid)
    else $error("producing beat not captured");

  a_span_moves_out: assert property (@(posedge clk) disable iff (rst)
    o_load |=> out_valid)
    else $error("span lost on the way to the output register");

  a_column_bound: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> (column_index <= CIW'(GRAPH_COLUMNS)))
    else $error("column count beyond graph width");
`endif

endmodule

// ===== src/wcsp_span_calc.sv =====
// ----------------------------------------------------------------------------
// wcsp_span_calc
// Rows, clamp, span length and wrapped frame index for one span request.
// ----------------------------------------------------------------------------
module wcsp_span_calc
  import wcsp_pkg::*;
#(
  parameter int FRAME_WIDTH  = DEF_FRAME_WIDTH,
  parameter int FRAME_HEIGHT = DEF_FRAME_HEIGHT
) (
  input  cfg_t      cfg,
  input  span_req_t req,
  output span_t     span
);

  localparam int RW           = $clog2(FRAME_HEIGHT);
  localparam int FRAME_PIXELS = FRAME_WIDTH * FRAME_HEIGHT;
  localparam int SW           = $clog2(FRAME_PIXELS + 1024);
  localparam int WRAPS        = 1 + 1022 / FRAME_PIXELS;

  function automatic logic [RW-1:0] row_of(input logic signed [SAMPLE_W-1:0] s,
                                           input logic [8:0] base,
                                           input logic [SHIFT_W-1:0] shift);
    logic signed [SAMPLE_W-1:0] sh;
    logic signed [17:0]         y;
    logic [RW-1:0]              r;
    sh = s >>> shift;
    y  = $signed({9'b0, base}) - 18'(sh);
    if (y < 0) begin
      r = '0;
    end else if (y > 18'(FRAME_HEIGHT - 1)) begin
      r = RW'(FRAME_HEIGHT - 1);
    end else begin
      r = RW'(y);
    end
    return r;
  endfunction

  logic [8:0]          base;
  logic [RW-1:0]       row0;
  logic [RW-1:0]       row1;
  logic [RW-1:0]       top;
  logic signed [16:0]  diff;
  logic [15:0]         len;
  logic [COL_X_W-1:0]  cx;
  logic [SW-1:0]       idx;

  assign base = {1'b0, cfg.rect_y} + {2'b0, cfg.rect_height[HEIGHT_W-1:1]};
  assign row0 = row_of(req.prev, base, cfg.amp_shift);
  assign row1 = row_of(req.sample, base, cfg.amp_shift);
  assign top  = (row0 < row1) ? row0 : row1;
  assign diff = 17'(req.sample) - 17'(req.prev);
  assign len  = diff[16] ? 16'(-diff) : 16'(diff);
  assign cx   = {1'b0, cfg.rect_x} + COL_X_W'(req.col);

  // sum stays below frame + 1023, so WRAPS conditional subtracts wrap it
  always_comb begin
    idx = SW'(top) * SW'(FRAME_WIDTH) + SW'(cx);
    for (int i = 0; i < WRAPS; i++) begin
      if (idx >= SW'(FRAME_PIXELS)) begin
        idx = idx - SW'(FRAME_PIXELS);
      end
    end
  end

  assign span.column_x    = cx;
  assign span.top_row     = ROW_W'(top);
  assign span.pixel_count = COUNT_W'(len >> cfg.amp_shift) + COUNT_W'(1);
  assign span.start_index = INDEX_W'(idx);
  assign span.last_column = req.last;

endmodule

// ===== bench/wcsp_span_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wcsp_span_checker
// Watches the sample, span and register channels of the column span plotter.
// Keeps its own copy of the registers and the block counters, works out the
// span, if any, due for each accepted sample beat and compares each accepted span
// beat, field by field, with the oldest one still outstanding.
// ----------------------------------------------------------------------------
module wcsp_span_checker
  import wcsp_pkg::*;
#(
  parameter int FRAME_WIDTH   = DEF_FRAME_WIDTH,
  parameter int FRAME_HEIGHT  = DEF_FRAME_HEIGHT,
  parameter int GRAPH_COLUMNS = DEF_GRAPH_COLUMNS
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       wr_en,
  input  logic [CFG_INDEX_W-1:0]     wr_index,
  input  logic [CFG_DATA_W-1:0]      wr_data,
  input  logic                       in_valid,
  input  logic                       in_stall,
  input  logic signed [SAMPLE_W-1:0] sample,
  input  logic                       first_of_block,
  input  logic                       out_valid,
  input  logic                       out_stall,
  input  logic [COL_X_W-1:0]         column_x,
  input  logic [ROW_W-1:0]           top_row,
  input  logic [COUNT_W-1:0]         pixel_count,
  input  logic [INDEX_W-1:0]         start_index,
  input  logic                       last_column,
  output int                         fails,
  output int                         pending,
  output int                         checked
);

  cfg_t                       shadow;
  logic [DEC_W-1:0]           phase_cnt;
  logic [MAX_COL_W:0]         kept_cnt;
  logic signed [SAMPLE_W-1:0] prev_kept;
  span_t                      spans_due[$];
  int                         n_fail = 0;
  int                         n_checked = 0;

  initial begin
    fails   = 0;
    pending = 0;
    checked = 0;
  end

  task automatic report_mismatch(string msg);
    $display("span_chk: beat %0d: %s", n_checked, msg);
    n_fail++;
  endtask

  function automatic int clamped_row(logic signed [SAMPLE_W-1:0] s);
    int y;
    y = int'(shadow.rect_y) + int'(shadow.rect_height >> 1) - (int'(s) >>> shadow.amp_shift);
    if (y < 0) y = 0;
    if (y > FRAME_HEIGHT - 1) y = FRAME_HEIGHT - 1;
    return y;
  endfunction

  task automatic take_sample(logic signed [SAMPLE_W-1:0] s, logic fob);
    int    dec_eff;
    int    nxt;
    logic  hit;
    int    y0, y1, top, diff, cx, col;
    span_t sp;
    dec_eff = (shadow.decimation == '0) ? 1 : int'(shadow.decimation);
    if (fob) begin
      phase_cnt = '0;
      kept_cnt  = '0;
    end
    hit = (phase_cnt == '0);
    nxt = int'(phase_cnt) + 1;
    phase_cnt = (nxt >= dec_eff) ? '0 : DEC_W'(nxt);
    if (!hit || kept_cnt >= GRAPH_COLUMNS) return;
    if (kept_cnt != '0) begin
      col  = int'(kept_cnt) - 1;
      y0   = clamped_row(prev_kept);
      y1   = clamped_row(s);
      top  = (y0 < y1) ? y0 : y1;
      diff = int'(s) - int'(prev_kept);
      if (diff < 0) diff = -diff;
      cx   = int'(shadow.rect_x) + col;
      sp.column_x    = COL_X_W'(cx);
      sp.top_row     = ROW_W'(top);
      sp.pixel_count = COUNT_W'((diff >> shadow.amp_shift) + 1);
      sp.start_index = INDEX_W'((cx + top * FRAME_WIDTH) % (FRAME_WIDTH * FRAME_HEIGHT));
      sp.last_column = (col == GRAPH_COLUMNS - 2);
      spans_due.push_back(sp);
    end
    prev_kept = s;
    kept_cnt++;
  endtask

  task automatic check_span();
    span_t want;
    if (spans_due.size() == 0) begin
      report_mismatch($sformatf("unexpected span beat, column_x %0d", column_x));
      return;
    end
    want = spans_due.pop_front();
    if (column_x !== want.column_x)
      report_mismatch($sformatf("column_x %0d, want %0d", column_x, want.column_x));
    if (top_row !== want.top_row)
      report_mismatch($sformatf("top_row %0d, want %0d", top_row, want.top_row));
    if (pixel_count !== want.pixel_count)
      report_mismatch($sformatf("pixel_count %0d, want %0d", pixel_count, want.pixel_count));
    if (start_index !== want.start_index)
      report_mismatch($sformatf("start_index %0d, want %0d", start_index, want.start_index));
    if (last_column !== want.last_column)
      report_mismatch($sformatf("last_column %0b, want %0b", last_column, want.last_column));
    n_checked++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      shadow.rect_x      = '0;
      shadow.rect_y      = '0;
      shadow.rect_height = '0;
      shadow.decimation  = DEC_W'(1);
      shadow.amp_shift   = '0;
      phase_cnt          = '0;
      kept_cnt           = '0;
      prev_kept          = '0;
      spans_due.delete();
    end else begin
      // output first: a span leaving now never belongs to a beat taken now
      if (out_valid && !out_stall) check_span();
      if (in_valid && !in_stall) take_sample(sample, first_of_block);
      if (wr_en) begin
        case (wr_index)
          REG_RECT_X:      shadow.rect_x      = wr_data[RECT_X_W-1:0];
          REG_RECT_Y:      shadow.rect_y      = wr_data[RECT_Y_W-1:0];
          REG_RECT_HEIGHT: shadow.rect_height = wr_data[HEIGHT_W-1:0];
          REG_DECIMATION:  shadow.decimation  = wr_data[DEC_W-1:0];
          REG_AMP_SHIFT:   shadow.amp_shift   = wr_data[SHIFT_W-1:0];
          default: ;
        endcase
      end
    end
    fails   <= n_fail;
    pending <= spans_due.size();
    checked <= n_checked;
  end

endmodule

// ===== bench/waveform_column_span_plotter_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// waveform_column_span_plotter_core_tb
// Drives sample beats and register writes into the column span plotter and
// lets wcsp_span_checker judge every span beat. A directed opening hits the
// sample extremes, row clamps, zero and maximum decimation and a decimation
// change mid-block; random phases then run block-shaped sample streams under
// several register settings with varied sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module waveform_column_span_plotter_core_tb;
  import wcsp_pkg::*;

  localparam int HOLD_CYCLES = 200;
  localparam logic signed [SAMPLE_W-1:0] S_MIN = 16'sh8000;
  localparam logic signed [SAMPLE_W-1:0] S_MAX = 16'sh7FFF;

  typedef enum int {NO_PRESSURE, HOLD_OUTPUT, DRAIN_MIDWAY} pressure_t;

  logic                       clk            = 1'b0;
  logic                       rst            = 1'b1;
  logic                       wr_en          = 1'b0;
  logic [CFG_INDEX_W-1:0]     wr_index       = '0;
  logic [CFG_DATA_W-1:0]      wr_data        = '0;
  logic                       in_valid       = 1'b0;
  logic                       in_stall;
  logic signed [SAMPLE_W-1:0] sample         = '0;
  logic                       first_of_block = 1'b0;
  logic                       out_valid;
  logic                       out_stall      = 1'b0;
  logic [COL_X_W-1:0]         column_x;
  logic [ROW_W-1:0]           top_row;
  logic [COUNT_W-1:0]         pixel_count;
  logic [INDEX_W-1:0]         start_index;
  logic                       last_column;

  int fails, pending, checked;

  int tx_pct     = 0;
  int rx_pct     = 0;
  int hold_kicks = 0;
  int hold_seen  = 0;
  int hold_left  = 0;

  int                         block_left  = 0;
  bit                         noisy_block = 1'b0;
  bit                         long_next   = 1'b0;
  int                         cur_dec     = 1;
  logic signed [SAMPLE_W-1:0] last_sample = '0;
  int                         n_sent      = 0;
  int                         n_settings  = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  waveform_column_span_plotter_core uut (
    .clk, .rst, .wr_en, .wr_index, .wr_data,
    .in_valid, .in_stall, .sample, .first_of_block,
    .out_valid, .out_stall, .column_x, .top_row, .pixel_count, .start_index, .last_column
  );

  wcsp_span_checker span_chk (
    .clk, .rst, .wr_en, .wr_index, .wr_data,
    .in_valid, .in_stall, .sample, .first_of_block,
    .out_valid, .out_stall, .column_x, .top_row, .pixel_count, .start_index, .last_column,
    .fails, .pending, .checked
  );

  // receiver: random stalls, or a long hold-off when kicked
  always @(posedge clk) begin
    if (hold_kicks != hold_seen) begin
      hold_seen <= hold_kicks;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < rx_pct);
    end
  end

  function automatic cfg_t setting(int x, int y, int h, int d, int sh);
    cfg_t c;
    c.rect_x      = RECT_X_W'(x);
    c.rect_y      = RECT_Y_W'(y);
    c.rect_height = HEIGHT_W'(h);
    c.decimation  = DEC_W'(d);
    c.amp_shift   = SHIFT_W'(sh);
    return c;
  endfunction

  task automatic send_beat(logic signed [SAMPLE_W-1:0] s, logic fob);
    while ($urandom_range(0, 99) < tx_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    sample         <= s;
    first_of_block <= fob;
    do @(posedge clk); while (in_stall);
    n_sent++;
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic put_reg(cfg_reg_t r, logic [CFG_DATA_W-1:0] v);
    wr_en    <= 1'b1;
    wr_index <= r;
    wr_data  <= v;
    @(posedge clk);
  endtask

  task automatic apply_setting(cfg_t c);
    settle();
    put_reg(REG_RECT_X,      CFG_DATA_W'(c.rect_x));
    put_reg(REG_RECT_Y,      CFG_DATA_W'(c.rect_y));
    put_reg(REG_RECT_HEIGHT, CFG_DATA_W'(c.rect_height));
    put_reg(REG_DECIMATION,  c.decimation);
    put_reg(REG_AMP_SHIFT,   CFG_DATA_W'(c.amp_shift));
    wr_en   <= 1'b0;
    cur_dec = (c.decimation == '0) ? 1 : int'(c.decimation);
    n_settings++;
  endtask

  // mostly well-formed blocks; some noise blocks with stray block marks
  task automatic make_beat(output logic signed [SAMPLE_W-1:0] s, output logic fob);
    int kind;
    if (block_left == 0) begin
      noisy_block = !long_next && ($urandom_range(0, 9) == 0);
      if (noisy_block)
        block_left = $urandom_range(1, 20);
      else if (long_next || $urandom_range(0, 5) == 0)
        block_left = cur_dec * $urandom_range(256, 280);
      else
        block_left = $urandom_range(3, 60);
      long_next = 1'b0;
      fob = noisy_block ? ($urandom_range(0, 2) == 0) : 1'b1;
    end else begin
      fob = noisy_block ? ($urandom_range(0, 2) == 0) : 1'b0;
    end
    block_left--;
    kind = $urandom_range(0, 9);
    case (kind)
      0:       s = $urandom_range(0, 1) ? S_MAX : S_MIN;
      1, 2, 3: s = SAMPLE_W'($urandom_range(0, 128)) - 16'sd64;
      4, 5:    s = last_sample + SAMPLE_W'($urandom_range(0, 2048)) - 16'sd1024;
      default: s = SAMPLE_W'($urandom());
    endcase
    last_sample = s;
  endtask

  task automatic run_phase(cfg_t c, int n, int tx, int rx, pressure_t p);
    logic signed [SAMPLE_W-1:0] s;
    logic                       fob;
    apply_setting(c);
    tx_pct = tx;
    rx_pct <= rx;
    if (p == HOLD_OUTPUT) hold_kicks <= hold_kicks + 1;
    for (int i = 0; i < n; i++) begin
      if (p == DRAIN_MIDWAY && i == n / 2) settle();
      make_beat(s, fob);
      send_beat(s, fob);
    end
  endtask

  initial begin
    int waited;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset registers, no block mark yet: rows clamp at both ends
    send_beat(16'sd0, 1'b0);
    send_beat(S_MAX, 1'b0);
    send_beat(S_MIN, 1'b0);
    send_beat(S_MAX, 1'b0);
    send_beat(-16'sd1, 1'b0);
    send_beat(16'sd1, 1'b0);
    send_beat(S_MIN, 1'b0);
    send_beat(16'sd0, 1'b1);
    send_beat(-16'sd100, 1'b0);
    send_beat(16'sd100, 1'b1);
    send_beat(S_MAX, 1'b0);

    // register extremes, decimation of zero keeps every sample
    apply_setting(setting(511, 255, 255, 0, 15));
    send_beat(S_MIN, 1'b1);
    send_beat(S_MAX, 1'b0);
    send_beat(S_MIN, 1'b0);
    send_beat(16'sd0, 1'b0);
    send_beat(-16'sd1, 1'b0);

    // widest decimation, then a smaller one while the phase is mid-way
    apply_setting(setting(319, 239, 239, 65535, 1));
    send_beat(16'sd5, 1'b1);
    for (int i = 0; i < 4; i++) send_beat(SAMPLE_W'($urandom()), 1'b0);
    apply_setting(setting(300, 200, 100, 3, 2));
    for (int i = 0; i < 4; i++) send_beat(SAMPLE_W'($urandom()), 1'b0);

    run_phase(setting($urandom_range(0, 319), $urandom_range(0, 239),
                      $urandom_range(0, 239), 1, $urandom_range(5, 10)),
              80, 0, 0, NO_PRESSURE);
    run_phase(setting($urandom_range(0, 319), $urandom_range(0, 239),
                      $urandom_range(0, 239), 2, $urandom_range(0, 15)),
              80, 73, 0, NO_PRESSURE);
    block_left = 0;
    long_next  = 1'b1;
    run_phase(setting(0, 0, 239, 1, 8), 300, 0, 73, NO_PRESSURE);
    run_phase(setting($urandom_range(0, 319), $urandom_range(0, 239),
                      $urandom_range(0, 239), 3, $urandom_range(4, 12)),
              80, 16, 16, NO_PRESSURE);
    run_phase(setting(511, 255, 255, 1, 15), 80, 0, 0, HOLD_OUTPUT);
    run_phase(setting(0, 0, 0, 0, 0), 80, 73, 0, DRAIN_MIDWAY);
    run_phase(setting($urandom_range(0, 511), $urandom_range(0, 255),
                      $urandom_range(0, 255), 2, $urandom_range(0, 15)),
              80, 16, 16, NO_PRESSURE);
    run_phase(setting($urandom_range(0, 319), 239, 0, 1, 8), 80, 0, 0, NO_PRESSURE);

    in_valid <= 1'b0;
    waited = 0;
    do begin
      @(posedge clk);
      waited++;
    end while (pending != 0 && waited < 20000);
    repeat (4) @(posedge clk);

    $display("tb: %0d sample beats sent under %0d register settings, %0d spans checked",
             n_sent, n_settings, checked);
    $display("tb: ran with free flow, sender gaps, output stalls, a long hold-off and a drain");
    if (pending != 0) $display("tb: %0d spans never arrived", pending);
    if (fails == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #7_200_000;
    $display("tb: failure");
    $finish;
  end

endmodule

// ===== files.f =====
src/wcsp_pkg.sv
src/wcsp_span_calc.sv
src/waveform_column_span_plotter_core.sv
bench/wcsp_span_checker.sv
bench/waveform_column_span_plotter_core_tb.sv
